@@ hw/rtl/imhdk_pkg.sv @@
// shared types and constants for the indexed min-heap block
`timescale 1ns / 1ps

package imhdk_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_BITS_DEF = 32;
	localparam int VERTEX_COUNT = 1024;
	localparam int VERTEX_BITS  = 10;
	localparam int KEY_IN_BITS  = 32;
	localparam int STATUS_BITS  = 3;
	localparam int COUNT_BITS   = 11;

	typedef enum logic [1:0] {
		KIND_INSERT   = 2'd0,
		KIND_EXTRACT  = 2'd1,
		KIND_DECREASE = 2'd2
	} kind_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_OK        = 3'd0,
		STAT_EMPTY     = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_ABSENT    = 3'd3,
		STAT_NOT_LOWER = 3'd4,
		STAT_PRESENT   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS_CHK,
		ST_DEC_CHK,
		ST_DEC_KEY,
		ST_UP_RD,
		ST_UP_CMP,
		ST_EXT_TOP,
		ST_EXT_LAST,
		ST_DN_RD,
		ST_DN_C1,
		ST_DN_C2,
		ST_DN_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [VERTEX_BITS-1:0] vertex_id;
		logic [KEY_IN_BITS-1:0] key_value;
	} cmd_t;

	typedef struct packed {
		logic [VERTEX_BITS-1:0] out_vertex;
		logic [KEY_IN_BITS-1:0] out_key;
		logic [STATUS_BITS-1:0] status;
		logic [COUNT_BITS-1:0]  entry_count;
	} rsp_t;

endpackage

@@ hw/rtl/indexed_min_heap_decrease_key.sv @@
// Indexed binary min-heap: insert, extract-min and decrease-key, one item at a time.
// Insert and decrease-key sift the entry up level by level; extract-min moves the last entry to
// the root and sifts it down level by level; an extract on an empty heap goes straight to its result.
// A stalled result holds the input off until taken.
// After reset the position memory is cleared, one vertex per cycle, stall high.
`timescale 1ns / 1ps

module indexed_min_heap_decrease_key import imhdk_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IW     = SLOT_W + 2;
	localparam int HW     = VERTEX_BITS + KEY_BITS;
	localparam int PW     = SLOT_W + 1;

	state_t state_q, state_d;

	logic [CNT_W-1:0]       count_q;
	logic [VERTEX_BITS-1:0] clr_q;
	logic [SLOT_W-1:0]      s_q;
	logic [SLOT_W-1:0]      sm_slot_q;
	logic [CNT_W-1:0]       n_q;
	logic [VERTEX_BITS-1:0] v_q;
	logic [VERTEX_BITS-1:0] sm_v_q;
	logic [VERTEX_BITS-1:0] ov_q;
	logic [KEY_BITS-1:0]    k_q;
	logic [KEY_BITS-1:0]    sm_k_q;
	logic [KEY_BITS-1:0]    ok_q;
	status_t                status_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	logic                   h_we;
	logic [SLOT_W-1:0]      h_waddr;
	logic [HW-1:0]          h_wdata;
	logic [SLOT_W-1:0]      h_raddr;
	logic [HW-1:0]          h_rdata;
	logic                   p_we;
	logic [VERTEX_BITS-1:0] p_waddr;
	logic [PW-1:0]          p_wdata;
	logic [VERTEX_BITS-1:0] p_raddr;
	logic [PW-1:0]          p_rdata;

	logic [VERTEX_BITS-1:0] h_rd_v;
	logic [KEY_BITS-1:0]    h_rd_k;
	logic                   p_rd_present;
	logic [SLOT_W-1:0]      p_rd_slot;

	logic [SLOT_W-1:0]      parent;
	logic [IW-1:0]          c1;
	logic [IW-1:0]          c2;
	logic [CNT_W-1:0]       last;
	logic [KEY_BITS-1:0]    key_in;
	logic [KEY_BITS-1:0]    lt_a;
	logic [KEY_BITS-1:0]    lt_b;
	logic                   lt;
	logic                   accept;
	logic                   rsp_free;
	logic                   rsp_load;
	logic                   ins_ok;

	imhdk_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	// position map: {present, slot} per vertex
	imhdk_ram #(.WIDTH(PW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	assign h_rd_v       = h_rdata[KEY_BITS +: VERTEX_BITS];
	assign h_rd_k       = h_rdata[KEY_BITS-1:0];
	assign p_rd_present = p_rdata[SLOT_W];
	assign p_rd_slot    = p_rdata[SLOT_W-1:0];

	assign parent   = (s_q - SLOT_W'(1)) >> 1;
	assign c1       = IW'({s_q, 1'b1});
	assign c2       = c1 + IW'(1);
	assign last     = count_q - CNT_W'(1);
	assign key_in   = KEY_BITS'(cmd.key_value);
	assign accept   = cmd_valid && !cmd_stall;
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign rsp_load = (state_q == ST_DONE) && rsp_free;
	assign ins_ok   = (state_q == ST_INS_CHK) && !p_rd_present
		&& (count_q < CNT_W'(CAPACITY));

	// shared key comparator: lt_a < lt_b
	always_comb begin
		lt_a = k_q;
		lt_b = h_rd_k;
		unique case (state_q)
			ST_DN_C2: begin
				lt_a = h_rd_k;
				lt_b = sm_k_q;
			end
			ST_DN_CMP: begin
				lt_a = sm_k_q;
				lt_b = k_q;
			end
			default: ;
		endcase
	end

	assign lt = lt_a < lt_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		h_we      = 1'b0;
		h_waddr   = s_q;
		h_wdata   = {v_q, k_q};
		h_raddr   = '0;
		p_we      = 1'b0;
		p_waddr   = v_q;
		p_wdata   = {1'b1, s_q};
		p_raddr   = cmd.vertex_id;
		unique case (state_q)
			ST_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = '0;
				if (clr_q == VERTEX_BITS'(VERTEX_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					unique case (cmd.kind)
						KIND_INSERT:   state_d = ST_INS_CHK;
						KIND_EXTRACT:  state_d = (count_q == '0) ? ST_DONE : ST_EXT_TOP;
						KIND_DECREASE: state_d = ST_DEC_CHK;
						default:       state_d = ST_DONE;
					endcase
				end
			end
			ST_INS_CHK: begin
				state_d = ins_ok ? ST_UP_RD : ST_DONE;
			end
			ST_DEC_CHK: begin
				if (!p_rd_present || CNT_W'(p_rd_slot) >= count_q) begin
					state_d = ST_DONE;
				end else begin
					h_raddr = p_rd_slot;
					state_d = ST_DEC_KEY;
				end
			end
			ST_DEC_KEY: begin
				state_d = lt ? ST_UP_RD : ST_DONE;
			end
			ST_UP_RD: begin
				if (s_q == '0) begin
					h_we    = 1'b1;
					p_we    = 1'b1;
					state_d = ST_DONE;
				end else begin
					h_raddr = parent;
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				h_we = 1'b1;
				p_we = 1'b1;
				if (lt) begin
					// parent moves down into the hole
					h_wdata = h_rdata;
					p_waddr = h_rd_v;
					state_d = ST_UP_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_EXT_TOP: begin
				p_we    = 1'b1;
				p_waddr = h_rd_v;
				p_wdata = '0;
				if (count_q == CNT_W'(1)) begin
					state_d = ST_DONE;
				end else begin
					h_raddr = last[SLOT_W-1:0];
					state_d = ST_EXT_LAST;
				end
			end
			ST_EXT_LAST: begin
				state_d = ST_DN_RD;
			end
			ST_DN_RD: begin
				if (c1 >= IW'(n_q)) begin
					h_we    = 1'b1;
					p_we    = 1'b1;
					state_d = ST_DONE;
				end else begin
					h_raddr = c1[SLOT_W-1:0];
					state_d = ST_DN_C1;
				end
			end
			ST_DN_C1: begin
				if (c2 < IW'(n_q)) begin
					h_raddr = c2[SLOT_W-1:0];
					state_d = ST_DN_C2;
				end else begin
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_C2: begin
				state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				h_we = 1'b1;
				p_we = 1'b1;
				if (lt) begin
					// smaller child moves up into the hole
					h_wdata = {sm_v_q, sm_k_q};
					p_waddr = sm_v_q;
					state_d = ST_DN_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + VERTEX_BITS'(1);
			end
			if (ins_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (state_q == ST_EXT_TOP) begin
				count_q <= last;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					v_q      <= cmd.vertex_id;
					k_q      <= key_in;
					ov_q     <= '0;
					ok_q     <= '0;
					status_q <= (cmd.kind == KIND_EXTRACT && count_q == '0)
						? STAT_EMPTY : STAT_OK;
				end
			end
			ST_INS_CHK: begin
				s_q <= SLOT_W'(count_q);
				if (p_rd_present) begin
					status_q <= STAT_PRESENT;
				end else if (count_q >= CNT_W'(CAPACITY)) begin
					status_q <= STAT_FULL;
				end
			end
			ST_DEC_CHK: begin
				s_q <= p_rd_slot;
				if (!p_rd_present || CNT_W'(p_rd_slot) >= count_q) begin
					status_q <= STAT_ABSENT;
				end
			end
			ST_DEC_KEY: begin
				if (!lt) begin
					status_q <= STAT_NOT_LOWER;
				end
			end
			ST_UP_CMP: begin
				if (lt) begin
					s_q <= parent;
				end
			end
			ST_EXT_TOP: begin
				ov_q <= h_rd_v;
				ok_q <= h_rd_k;
				n_q  <= last;
				s_q  <= '0;
			end
			ST_EXT_LAST: begin
				// last entry becomes the one sifted down from the root
				v_q <= h_rd_v;
				k_q <= h_rd_k;
			end
			ST_DN_C1: begin
				sm_v_q    <= h_rd_v;
				sm_k_q    <= h_rd_k;
				sm_slot_q <= c1[SLOT_W-1:0];
			end
			ST_DN_C2: begin
				if (lt) begin
					sm_v_q    <= h_rd_v;
					sm_k_q    <= h_rd_k;
					sm_slot_q <= c2[SLOT_W-1:0];
				end
			end
			ST_DN_CMP: begin
				if (lt) begin
					s_q <= sm_slot_q;
				end
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_q.out_vertex  <= ov_q;
			rsp_q.out_key     <= KEY_IN_BITS'(ok_q);
			rsp_q.status      <= status_q;
			rsp_q.entry_count <= COUNT_BITS'(count_q);
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + CNT_W'(1) || count_q == $past(count_q) - CNT_W'(1)))
		else $error("entry count moved by more than one");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cmd_stall)
		else $error("item accepted while previous one still in work");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without a finished operation");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == STAT_EMPTY |-> rsp_q.entry_count == '0)
		else $error("empty status with nonzero entry count");

endmodule

@@ hw/rtl/imhdk_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module imhdk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
